### hdl/kahan_compensated_sum_assert.svh
// ----------------------------------------------------------------------------
// kahan_compensated_sum_assert.svh
// Assertion macros for the compensated sum block.
// ----------------------------------------------------------------------------
`ifndef KAHAN_COMPENSATED_SUM_ASSERT_SVH
`define KAHAN_COMPENSATED_SUM_ASSERT_SVH

// same-cycle implication
`define KCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/kcs_pkg.sv
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types and constants for the compensated sum block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kcs_pkg;

  localparam logic KIND_REAL = 1'b0;
  localparam logic KIND_INT  = 1'b1;

  typedef struct packed {
    logic [63:0] sum;
    logic [63:0] comp;
  } acc_t;

endpackage

`default_nettype wire

### hdl/kcs_fold.sv
// ----------------------------------------------------------------------------
// kcs_fold
// One Kahan step: binary64 (round to nearest even) or 32-bit wrapping.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kcs_fold import kcs_pkg::*; (
  input  wire logic        kind,
  input  wire logic [63:0] value,
  input  wire acc_t        acc,
  output acc_t             acc_next
);

  // a + b, or a - b when sub is set; x86 NaN propagation
  function automatic logic [63:0] fp_add(input logic [63:0] a, input logic [63:0] b,
                                         input logic sub);
    logic        a_nan, b_nan, a_inf, b_inf, sb;
    logic [63:0] x, y, res;
    logic        sx, sy, hx, hy, stk, g, rs, inc;
    logic [11:0] ex, ey, d, e, sh, lim;
    logic [55:0] mx, my, mys;
    logic [56:0] s;
    logic [5:0]  lz;
    logic [52:0] m;
    logic [53:0] mr;
    a_nan = (&a[62:52]) && (|a[51:0]);
    b_nan = (&b[62:52]) && (|b[51:0]);
    a_inf = (&a[62:52]) && !(|a[51:0]);
    b_inf = (&b[62:52]) && !(|b[51:0]);
    sb    = b[63] ^ sub;
    res   = '0;
    lz    = '0;
    if (a_nan) begin
      res = a | 64'h0008_0000_0000_0000;
    end else if (b_nan) begin
      res = b | 64'h0008_0000_0000_0000;
    end else if (a_inf && b_inf) begin
      res = (a[63] != sb) ? 64'hFFF8_0000_0000_0000 : a;
    end else if (a_inf) begin
      res = a;
    end else if (b_inf) begin
      res = {sb, b[62:0]};
    end else begin
      if (a[62:0] >= b[62:0]) begin
        x = a; sx = a[63]; y = b; sy = sb;
      end else begin
        x = b; sx = sb; y = a; sy = a[63];
      end
      hx  = |x[62:52];
      hy  = |y[62:52];
      ex  = hx ? {1'b0, x[62:52]} : 12'd1;
      ey  = hy ? {1'b0, y[62:52]} : 12'd1;
      mx  = {hx, x[51:0], 3'b000};
      my  = {hy, y[51:0], 3'b000};
      d   = ex - ey;
      if (d >= 12'd56) begin
        mys = '0;
        stk = |my;
      end else begin
        mys = my >> d;
        stk = |(my & ~({56{1'b1}} << d));
      end
      mys[0] = mys[0] | stk;
      s = (sx == sy) ? ({1'b0, mx} + {1'b0, mys}) : ({1'b0, mx} - {1'b0, mys});
      e = ex;
      if (s == '0) begin
        res = {sx & sy, 63'd0};
      end else begin
        if (s[56]) begin
          s = {1'b0, s[56:2], s[1] | s[0]};
          e = e + 12'd1;
        end else begin
          for (int i = 0; i < 56; i++) begin
            if (s[i]) lz = 6'(55 - i);
          end
          lim = e - 12'd1;
          sh  = ({6'd0, lz} < lim) ? {6'd0, lz} : lim;
          s   = s << sh;
          e   = e - sh;
        end
        g   = s[2];
        rs  = s[1] | s[0];
        m   = s[55:3];
        inc = g & (rs | m[0]);
        mr  = {1'b0, m} + {53'd0, inc};
        if (mr[53]) begin
          m = mr[53:1];
          e = e + 12'd1;
        end else begin
          m = mr[52:0];
        end
        if (e >= 12'd2047) res = {sx, 11'h7FF, 52'd0};
        else               res = {sx, (m[52] ? e[10:0] : 11'd0), m[51:0]};
      end
    end
    return res;
  endfunction

  logic [63:0] ry, rt, rd, rc;
  logic [31:0] iy, it;

  always_comb begin
    ry = fp_add(value, acc.comp, 1'b1);
    rt = fp_add(acc.sum, ry, 1'b0);
    rd = fp_add(rt, acc.sum, 1'b1);
    rc = fp_add(rd, ry, 1'b1);
    iy = value[31:0] - acc.comp[31:0];
    it = acc.sum[31:0] + iy;
    if (kind == KIND_REAL) begin
      acc_next.sum  = rt;
      acc_next.comp = rc;
    end else begin
      // (t - s) - y is always zero in wrapping arithmetic
      acc_next.sum  = {32'd0, it};
      acc_next.comp = {32'd0, (it - acc.sum[31:0]) - iy};
    end
  end

endmodule

`default_nettype wire

### hdl/kahan_compensated_sum.sv
// ----------------------------------------------------------------------------
// kahan_compensated_sum
// Streaming Kahan-compensated sum of double or int32 elements.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one element per transaction, with
//   last_element marking the final element of a field.
//   Output channel (out_valid/out_stall): one transaction per field carrying
//   total_sum (double bits, or int32 sum sign-extended).
//   Config channel (cfg_valid/cfg_ready/cfg_data): sets data_kind
//   (0 double, 1 int32); write it only while the block is idle.
// Timing:
//   An element is registered on accept and folded into the accumulators as
//   it advances; total_sum is registered as a last element advances. One
//   element per cycle sustained unless a held result blocks a last element;
//   the limit is the comp feedback through four chained binary64 adders.
// Reset (rst, synchronous): clears accumulators, data_kind and both valids.
// Stall: a held result blocks only a following last element; ordinary
//   elements keep folding while the output waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "kahan_compensated_sum_assert.svh"

module kahan_compensated_sum import kcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [63:0] element_value,
  input  wire logic        last_element,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      total_sum
);

  logic        data_kind;
  logic        in_q_valid;
  logic [63:0] value_q;
  logic        last_q;
  acc_t        acc, acc_next;
  logic        advance;

  kcs_fold u_fold (
    .kind     (data_kind),
    .value    (value_q),
    .acc      (acc),
    .acc_next (acc_next)
  );

  // a last element needs the result register free
  assign advance   = in_q_valid && (!last_q || !out_valid || !out_stall);
  assign in_stall  = in_q_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_kind  <= KIND_REAL;
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
      acc        <= '0;
    end else begin
      if (cfg_valid) data_kind <= cfg_data;
      if (in_valid && !in_stall) in_q_valid <= 1'b1;
      else if (advance)          in_q_valid <= 1'b0;
      if (advance && last_q)     out_valid <= 1'b1;
      else if (!out_stall)       out_valid <= 1'b0;
      if (advance) acc <= last_q ? '0 : acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      value_q <= element_value;
      last_q  <= last_element;
    end
    if (advance && last_q) begin
      if (data_kind == KIND_REAL) total_sum <= acc_next.sum;
      else total_sum <= {{32{acc_next.sum[31]}}, acc_next.sum[31:0]};
    end
  end

  `KCS_ASSERT_NEXT(a_clear_on_last, advance && last_q, acc.sum == '0 && acc.comp == '0, "accumulators not cleared after last element")
  `KCS_ASSERT_NEXT(a_int_comp_zero, advance && (data_kind == KIND_INT), acc.comp == '0, "integer compensation nonzero")
  `KCS_ASSERT_NOW(a_stall_needs_item, in_stall, in_q_valid && last_q && out_valid, "input stalled without a blocked last element")

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for kahan_compensated_sum: streams double and int32
// fields through the block, predicts each field's compensated sum
// and compares every output transaction with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kcs_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic        last;
  } elem_t;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] element_value;
  logic        last_element;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] total_sum;

  kahan_compensated_sum u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .element_value(element_value), .last_element(last_element),
    .out_valid(out_valid), .out_stall(out_stall), .total_sum(total_sum)
  );

  // Elements waiting to be sent, and sums waiting to come out.
  elem_t       elem_q[$];
  logic [63:0] sum_q[$];

  // Predictor state, mirrors the accumulators and the mode register.
  logic [63:0] acc_sum;
  logic [63:0] acc_comp;
  logic        kind_now;

  int  errors;
  int  cycles;
  int  burst_left;
  int  gap_left;
  int  stall_mode;
  logic cfg_pending;
  logic cfg_next;
  int  cfg_done;

  // Fold one accepted element into the predicted accumulators; on the last
  // element of a field push the expected sum and clear.
  task automatic fold_element(input elem_t e);
    real v, s, c, y, t;
    logic [31:0] iv, is, ic, iy, it;
    if (kind_now == KIND_REAL) begin
      v = $bitstoreal(e.value);
      s = $bitstoreal(acc_sum);
      c = $bitstoreal(acc_comp);
      y = v - c;
      t = s + y;
      c = (t - s) - y;
      acc_sum  = $realtobits(t);
      acc_comp = $realtobits(c);
    end else begin
      // mode switch mid-field: old bits are read as int32, no conversion
      iv = e.value[31:0];
      is = acc_sum[31:0];
      ic = acc_comp[31:0];
      iy = iv - ic;
      it = is + iy;
      ic = (it - is) - iy;
      acc_sum  = {32'h0, it};
      acc_comp = {32'h0, ic};
    end
    if (e.last) begin
      if (kind_now == KIND_REAL) sum_q.push_back(acc_sum);
      else sum_q.push_back({{32{acc_sum[31]}}, acc_sum[31:0]});
      acc_sum  = '0;
      acc_comp = '0;
    end
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Input driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid      <= 1'b0;
      element_value <= '0;
      last_element  <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_element(elem_q.pop_front());
      end
      // a stalled transaction holds its payload
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (elem_q.size() > 0) begin
          in_valid      <= 1'b1;
          element_value <= elem_q[0].value;
          last_element  <= elem_q[0].last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall pattern: switches between never, light, heavy and near-solid runs.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ($urandom_range(0, 15) != 0);
      endcase
    end
  end

  // Output monitor
  always @(posedge clk) begin
    logic [63:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (sum_q.size() == 0) begin
        $error("total_sum: unexpected transaction, actual %h", total_sum);
        errors++;
      end else begin
        want = sum_q.pop_front();
        if (total_sum !== want) begin
          $error("total_sum: expected %h actual %h", want, total_sum);
          errors++;
        end
      end
    end
  end

  // Config channel driver; the model register changes at the handshake.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
      cfg_data  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      cfg_valid <= 1'b0;
      kind_now  <= cfg_data;
      cfg_done  <= cfg_done + 1;
    end else if (cfg_pending && !cfg_valid) begin
      cfg_valid   <= 1'b1;
      cfg_data    <= cfg_next;
      cfg_pending <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random element: in real mode mostly moderate magnitudes of mixed sign so
  // cancellation exercises the compensation, plus some raw bit patterns.
  function automatic logic [63:0] rand_element(input logic kind);
    logic [63:0] b;
    b = rand64();
    if (kind == KIND_REAL) begin
      if ($urandom_range(0, 9) != 0)
        b[62:52] = 11'(32'd1023 + $urandom_range(0, 60) - 32'd30);
    end else if ($urandom_range(0, 3) == 0) begin
      b[31:0] = ($urandom_range(0, 1) != 0) ? 32'h7fffffff - $urandom_range(0, 3)
                                           : 32'h80000000 + $urandom_range(0, 3);
    end
    return b;
  endfunction

  task automatic queue_element(input logic [63:0] v, input logic last);
    elem_t e;
    e.value = v;
    e.last  = last;
    elem_q.push_back(e);
  endtask

  // Random fields, mostly short; a few long ones.
  task automatic queue_fields(input int count, input logic kind);
    int n;
    while (count > 0) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (n > count) n = count;
      for (int i = 0; i < n; i++) queue_element(rand_element(kind), i == n - 1);
      count -= n;
    end
  endtask

  // Wait for the block to drain, then let its pipeline settle.
  task automatic wait_idle();
    @(negedge clk);
    while (elem_q.size() > 0 || in_valid || sum_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_kind(input logic k);
    int seen;
    @(negedge clk);
    seen        = cfg_done;
    cfg_next    = k;
    cfg_pending = 1'b1;
    while (cfg_done == seen) @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_data      = 1'b0;
    cfg_pending   = 1'b0;
    cfg_next      = 1'b0;
    cfg_done      = 0;
    in_valid      = 1'b0;
    element_value = '0;
    last_element  = 1'b0;
    out_stall     = 1'b0;
    acc_sum       = '0;
    acc_comp      = '0;
    kind_now      = KIND_REAL;
    errors        = 0;
    cycles        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed doubles: signed zeros, extremes, infinities, NaN, cancellation.
    queue_element(64'h0000000000000000, 1'b0);
    queue_element(64'h8000000000000000, 1'b1);
    queue_element(64'h7fefffffffffffff, 1'b0);
    queue_element(64'h7fefffffffffffff, 1'b1);      // overflow to infinity
    queue_element(64'h7ff0000000000000, 1'b0);
    queue_element(64'hfff0000000000000, 1'b1);      // inf - inf
    queue_element(64'h7ff8000000000001, 1'b0);
    queue_element(64'h3ff0000000000000, 1'b1);      // NaN propagates
    queue_element(64'h0000000000000001, 1'b0);
    queue_element(64'h8000000000000001, 1'b1);      // subnormals
    queue_element(64'h4340000000000000, 1'b0);      // 2^53
    queue_element(64'h3ff0000000000000, 1'b0);      // lost low bits kept in comp
    queue_element(64'h3ff0000000000000, 1'b0);
    queue_element(64'hc340000000000000, 1'b1);
    queue_element(64'hffffffffffffffff, 1'b1);
    wait_idle();

    // Directed int32: extremes, wrap, ignored upper half.
    write_kind(KIND_INT);
    queue_element(64'hffffffff7fffffff, 1'b0);
    queue_element(64'h0000000000000001, 1'b1);      // wraps negative
    queue_element(64'h0000000080000000, 1'b0);
    queue_element(64'h12345678ffffffff, 1'b1);
    queue_element(64'h0000000000000000, 1'b1);
    queue_element(64'hffffffffffffffff, 1'b1);
    wait_idle();

    // Mode switch mid-field in both directions: stored bits are reinterpreted.
    write_kind(KIND_REAL);
    queue_element(64'h400921fb54442d18, 1'b0);
    queue_element(64'h3c9cd2b297d889bc, 1'b0);
    wait_idle();
    write_kind(KIND_INT);
    queue_element(64'h0000000000000005, 1'b1);
    queue_element(64'h00000000fffffff0, 1'b0);
    wait_idle();
    write_kind(KIND_REAL);
    queue_element(64'h3ff8000000000000, 1'b1);
    wait_idle();

    // Random phases, alternating modes, ending some phases mid-field.
    for (int p = 0; p < 6; p++) begin
      queue_fields(200 + $urandom_range(0, 40), kind_now);
      if (p % 2 == 1) queue_element(rand_element(kind_now), 1'b0);
      wait_idle();
      write_kind(~kind_now);
    end
    queue_fields(40, kind_now);
    queue_element(rand_element(kind_now), 1'b1);
    wait_idle();
    repeat (10) @(negedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
